[src/ufrl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ufrl_pkg;

    // Flow table geometry; the depth is a power of two no larger than 65536 (the 16-bit fold)
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 48;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_PACKET_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

    localparam logic [31:0] PACKET_LIMIT_RST  = 32'd100;
    localparam logic [31:0] BYTE_LIMIT_RST    = 32'd500000;
    localparam logic [47:0] WINDOW_LENGTH_RST = 48'd1000000000;

    // Header checks
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] MIN_UDP_FRAME  = 16'd42;

    // Result reason codes
    localparam logic [1:0] REASON_NOT_UDP    = 2'd0;
    localparam logic [1:0] REASON_COUNTED    = 2'd1;
    localparam logic [1:0] REASON_PKT_LIMIT  = 2'd2;
    localparam logic [1:0] REASON_BYTE_LIMIT = 2'd3;

    typedef struct packed {
        logic [31:0] packet_limit;
        logic [31:0] byte_limit;
        logic [47:0] window_length;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [31:0]      packets;
        logic [31:0]      bytes;
        logic [63:0]      start;
    } entry_t;

    typedef struct packed {
        logic [15:0]      frame_len;
        logic [15:0]      ether_type;
        logic [7:0]       ip_protocol;
        logic [KEY_W-1:0] key;
        logic [15:0]      udp_length;
        logic [63:0]      now_ns;
    } item_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } tbl_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } tbl_wr_t;

    // XOR fold of the three key slices, reduced to a table slot
    function automatic logic [IDX_W-1:0] slot_of(input logic [KEY_W-1:0] key);
        logic [15:0] fold;
        fold = key[47:32] ^ key[31:16] ^ key[15:0];
        return fold[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/ufrl_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Header summary word
interface ufrl_hdr_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [15:0] udp_length;
    logic [63:0] now_ns;

    modport source (
        output valid, frame_len, ether_type, ip_protocol, src_addr, src_port,
               udp_length, now_ns,
        input  ready
    );
    modport sink (
        input  valid, frame_len, ether_type, ip_protocol, src_addr, src_port,
               udp_length, now_ns,
        output ready
    );
endinterface

// Verdict word
interface ufrl_res_if;
    logic       valid;
    logic       ready;
    logic       verdict;
    logic [1:0] reason;

    modport source (
        output valid, verdict, reason,
        input  ready
    );
    modport sink (
        input  valid, verdict, reason,
        output ready
    );
endinterface

`default_nettype wire

[src/ufrl_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module ufrl_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ufrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ufrl_pkg::CFG_DATA_W-1:0] cfg_data,
    output ufrl_pkg::cfg_t                  cfg
);
    import ufrl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PACKET_LIMIT:  cfg_next.packet_limit  = cfg_data[31:0];
                REG_BYTE_LIMIT:    cfg_next.byte_limit    = cfg_data[31:0];
                REG_WINDOW_LENGTH: cfg_next.window_length = cfg_data[47:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.packet_limit  <= PACKET_LIMIT_RST;
            cfg_reg.byte_limit    <= BYTE_LIMIT_RST;
            cfg_reg.window_length <= WINDOW_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[src/ufrl_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module ufrl_table (
    input  logic              clk,
    input  logic              rst_n,
    input  ufrl_pkg::tbl_rd_t rd,
    output ufrl_pkg::entry_t  rd_data,
    input  ufrl_pkg::tbl_wr_t wr,
    output logic              init_done
);
    import ufrl_pkg::*;

    entry_t           mem [TABLE_DEPTH];
    entry_t           rd_data_reg;
    logic [IDX_W:0]   clr_cnt_reg;
    logic [IDX_W:0]   clr_cnt_next;
    logic             mem_we;
    logic [IDX_W-1:0] mem_idx;
    entry_t           mem_wdata;

    assign init_done = clr_cnt_reg[IDX_W];

    // Sweep invalid entries through the table after reset, then take writes
    always_comb
    begin
        clr_cnt_next = init_done ? clr_cnt_reg : clr_cnt_reg + 1'b1;
        mem_we       = wr.en;
        mem_idx      = wr.idx;
        mem_wdata    = wr.data;
        if (!init_done)
        begin
            mem_we    = 1'b1;
            mem_idx   = clr_cnt_reg[IDX_W-1:0];
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Single-port write, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_idx] <= mem_wdata;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.idx];
        end
    end

    assign rd_data = rd_data_reg;

    // No flow update may collide with the clearing sweep
    a_no_write_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> init_done)
        else $error("flow table written during clearing sweep");

    // No lookup may read a half-cleared table
    a_no_read_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rd.en |-> init_done)
        else $error("flow table read during clearing sweep");

endmodule

`default_nettype wire

[src/udp_flow_rate_limiter.sv]
// UDP per-flow rate limiter.
// hdr carries one parsed header summary per word (valid/ready); res returns one
// verdict word per header: verdict 0 pass / 1 drop, and a reason code
// (not UDP or short, counted, packet limit, byte limit).
// UDP flows are keyed by source address and port and tracked in a direct-mapped
// table of TABLE_DEPTH entries held in one synchronous RAM (registered read).
// A header reads its table entry at the edge that accepts it; the verdict is
// registered as the sequencer leaves busy, once the output register is free.
// A new header is taken only once the one before has loaded its verdict, set by
// the read-modify-write of the single table RAM (read at accept, write back at load).
// A new header is taken while an earlier verdict still waits in the output
// register; if that verdict is still stalled when the next one is ready, the
// block holds the next one (and its table update) until res.ready is seen.
// Reset: the limit registers return to 100 packets, 500000 bytes and a 1 s
// window; the table is then swept invalid, one entry per cycle, through all
// TABLE_DEPTH (1024) entries, during which hdr.ready stays low. Configuration
// writes are taken at any time, and are meant to be issued while idle.
`timescale 1ns / 1ps
`default_nettype none

module udp_flow_rate_limiter (
    input  logic                            clk,
    input  logic                            rst_n,
    ufrl_hdr_if.sink                        hdr,
    ufrl_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [ufrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ufrl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ufrl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    item_t       item_reg;
    item_t       item_in;
    cfg_t        cfg;
    tbl_rd_t     tbl_rd;
    tbl_wr_t     tbl_wr;
    entry_t      rd_entry;
    logic        init_done;
    logic        accept;
    logic        out_free;
    logic        finish;

    logic        res_valid_reg;
    logic        res_valid_next;
    logic        verdict_reg;
    logic        verdict_next;
    logic [1:0]  reason_reg;
    logic [1:0]  reason_next;

    logic        not_udp;
    logic        hit;
    logic [63:0] elapsed;
    logic        expired;
    logic        fresh;
    logic [32:0] bytes_sum_hit;
    logic        pkt_drop;
    logic        byte_drop;
    entry_t      new_entry;

    ufrl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ufrl_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (tbl_rd),
        .rd_data   (rd_entry),
        .wr        (tbl_wr),
        .init_done (init_done)
    );

    // Input word
    assign hdr.ready = (state_reg == ST_IDLE) && init_done;
    assign accept    = hdr.valid && hdr.ready;

    always_comb
    begin
        item_in.frame_len   = hdr.frame_len;
        item_in.ether_type  = hdr.ether_type;
        item_in.ip_protocol = hdr.ip_protocol;
        item_in.key         = {hdr.src_addr, hdr.src_port};
        item_in.udp_length  = hdr.udp_length;
        item_in.now_ns      = hdr.now_ns;
    end

    // Look up the flow slot as the word is taken
    assign tbl_rd.en  = accept;
    assign tbl_rd.idx = slot_of(item_in.key);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    // Sequence: idle, then busy until the verdict register is free
    assign out_free = !res_valid_reg || res.ready;
    assign finish   = (state_reg == ST_BUSY) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_BUSY;
            ST_BUSY: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Classify the header; frames shorter than MIN_UDP_FRAME fail the single length check
    assign not_udp = (item_reg.ether_type != ETHERTYPE_IPV4) ||
                     (item_reg.ip_protocol != PROTO_UDP) ||
                     (item_reg.frame_len < MIN_UDP_FRAME);

    // Hit check and window expiry on the stored entry
    assign hit     = rd_entry.valid && (rd_entry.key == item_reg.key);
    assign elapsed = item_reg.now_ns - rd_entry.start;
    assign expired = elapsed > {16'd0, cfg.window_length};
    assign fresh   = !hit || expired;

    // Evaluate both the stored and the restarted counts, then pick one
    assign bytes_sum_hit = {1'b0, rd_entry.bytes} + {17'd0, item_reg.udp_length};
    assign pkt_drop  = fresh ? (cfg.packet_limit == 32'd0)
                             : (rd_entry.packets >= cfg.packet_limit);
    assign byte_drop = fresh ? ({16'd0, item_reg.udp_length} >= cfg.byte_limit)
                             : (bytes_sum_hit >= {1'b0, cfg.byte_limit});

    always_comb
    begin
        new_entry.valid   = 1'b1;
        new_entry.key     = item_reg.key;
        new_entry.packets = fresh ? 32'd1 : rd_entry.packets + 32'd1;
        new_entry.bytes   = fresh ? {16'd0, item_reg.udp_length} : bytes_sum_hit[31:0];
        new_entry.start   = fresh ? item_reg.now_ns : rd_entry.start;
    end

    // Write back counted packets only
    assign tbl_wr.en   = finish && !not_udp && !pkt_drop && !byte_drop;
    assign tbl_wr.idx  = slot_of(item_reg.key);
    assign tbl_wr.data = new_entry;

    // Verdict register
    always_comb
    begin
        res_valid_next = res_valid_reg && !res.ready;
        verdict_next   = verdict_reg;
        reason_next    = reason_reg;
        if (finish)
        begin
            res_valid_next = 1'b1;
            if (not_udp)
            begin
                verdict_next = 1'b0;
                reason_next  = REASON_NOT_UDP;
            end
            else if (pkt_drop)
            begin
                verdict_next = 1'b1;
                reason_next  = REASON_PKT_LIMIT;
            end
            else if (byte_drop)
            begin
                verdict_next = 1'b1;
                reason_next  = REASON_BYTE_LIMIT;
            end
            else
            begin
                verdict_next = 1'b0;
                reason_next  = REASON_COUNTED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        reason_reg  <= reason_next;
    end

    assign res.valid   = res_valid_reg;
    assign res.verdict = verdict_reg;
    assign res.reason  = reason_reg;

    // A taken header always moves the sequencer to busy
    a_accept_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_BUSY)
        else $error("accepted header did not start a lookup");

    // Drop verdicts carry a limit reason, pass verdicts do not
    a_verdict_reason: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.verdict == ((res.reason == REASON_PKT_LIMIT) ||
                                       (res.reason == REASON_BYTE_LIMIT))))
        else $error("verdict and reason disagree");

    // A table update only accompanies a counted verdict being loaded
    a_write_counted: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |=> res_valid_reg && (reason_reg == REASON_COUNTED))
        else $error("table written without a counted verdict");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ufrl_pkg::*;

    // Header length thresholds for the Ethernet and IPv4 stages
    localparam logic [15:0] ETH_HDR_END = 16'd14;
    localparam logic [15:0] IP_HDR_END  = 16'd34;

    // Index past the last register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int POOL_SIZE = 8;

    typedef struct {
        logic [15:0] frame_len;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] udp_length;
        logic [63:0] now_ns;
    } hdr_word_t;

    typedef struct packed {
        logic       verdict;
        logic [1:0] reason;
    } verdict_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ufrl_hdr_if hdr ();
    ufrl_res_if res ();

    udp_flow_rate_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Limits and flow table as the block should hold them
    logic [31:0] lim_packets;
    logic [31:0] lim_bytes;
    logic [47:0] win_len;
    logic        flow_valid [TABLE_DEPTH];
    logic [47:0] flow_key   [TABLE_DEPTH];
    logic [31:0] flow_pkts  [TABLE_DEPTH];
    logic [31:0] flow_bytes [TABLE_DEPTH];
    logic [63:0] flow_start [TABLE_DEPTH];

    hdr_word_t     pending_words[$];
    verdict_word_t expected_verdicts[$];
    int            outstanding = 0;
    int            mismatches  = 0;
    logic          hdr_took    = 1'b0;
    int            send_idle_pct;
    int            recv_idle_pct;

    // Stimulus flow pool and traffic clock
    logic [31:0] pool_addr [POOL_SIZE];
    logic [15:0] pool_port [POOL_SIZE];
    logic [63:0] wall_ns;

    always #4 clk = ~clk;

    // Fold the flow key into a table slot
    function automatic int unsigned flow_slot(logic [47:0] key);
        logic [15:0] fold;
        fold = key[47:32] ^ key[31:16] ^ key[15:0];
        return int'(fold) % TABLE_DEPTH;
    endfunction

    // Police one header against its flow entry and update the table
    function automatic verdict_word_t police_word(hdr_word_t w);
        verdict_word_t v;
        logic [47:0]   key;
        int unsigned   slot;
        logic [31:0]   pkts;
        logic [31:0]   bytes;
        logic [63:0]   start;
        logic [32:0]   total;
        v.verdict = 1'b0;
        v.reason  = REASON_NOT_UDP;
        if (w.frame_len < ETH_HDR_END || w.ether_type != ETHERTYPE_IPV4 ||
            w.frame_len < IP_HDR_END || w.ip_protocol != PROTO_UDP ||
            w.frame_len < MIN_UDP_FRAME)
            return v;
        key  = {w.src_addr, w.src_port};
        slot = flow_slot(key);
        if (flow_valid[slot] && flow_key[slot] == key)
        begin
            pkts  = flow_pkts[slot];
            bytes = flow_bytes[slot];
            start = flow_start[slot];
        end
        else
        begin
            pkts  = '0;
            bytes = '0;
            start = w.now_ns;
        end
        // Restart the window after a long gap or a clock that went back
        if (w.now_ns - start > {16'd0, win_len})
        begin
            pkts  = '0;
            bytes = '0;
            start = w.now_ns;
        end
        total = {1'b0, bytes} + {17'd0, w.udp_length};
        if (pkts >= lim_packets)
        begin
            v.verdict = 1'b1;
            v.reason  = REASON_PKT_LIMIT;
        end
        else if (total >= {1'b0, lim_bytes})
        begin
            v.verdict = 1'b1;
            v.reason  = REASON_BYTE_LIMIT;
        end
        else
        begin
            flow_valid[slot] = 1'b1;
            flow_key[slot]   = key;
            flow_pkts[slot]  = pkts + 32'd1;
            flow_bytes[slot] = total[31:0];
            flow_start[slot] = start;
            v.reason         = REASON_COUNTED;
        end
        return v;
    endfunction

    function automatic hdr_word_t udp_word(logic [31:0] addr, logic [15:0] port,
                                           logic [15:0] len, logic [63:0] t);
        hdr_word_t w;
        w.frame_len   = MIN_UDP_FRAME;
        w.ether_type  = ETHERTYPE_IPV4;
        w.ip_protocol = PROTO_UDP;
        w.src_addr    = addr;
        w.src_port    = port;
        w.udp_length  = len;
        w.now_ns      = t;
        return w;
    endfunction

    function automatic hdr_word_t raw_word(logic [15:0] flen, logic [15:0] etype,
                                           logic [7:0] proto);
        hdr_word_t w;
        w = udp_word(32'h0A00_0001, 16'd53, 16'd64, 64'd500);
        w.frame_len   = flen;
        w.ether_type  = etype;
        w.ip_protocol = proto;
        return w;
    endfunction

    task automatic queue_word(hdr_word_t w);
        pending_words.push_back(w);
        outstanding++;
    endtask

    // Wait until every verdict is back, then let the pipeline drain
    task automatic settle();
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PACKET_LIMIT:  lim_packets = val[31:0];
            REG_BYTE_LIMIT:    lim_bytes   = val[31:0];
            REG_WINDOW_LENGTH: win_len     = val[47:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed UDP on a small flow pool, some noise and short frames
    task automatic queue_random_word();
        hdr_word_t   w;
        int          pick;
        int          r;
        logic [63:0] step;
        r    = $urandom_range(0, 99);
        pick = $urandom_range(0, POOL_SIZE - 1);
        step = ({16'd0, win_len} >> 2) + 64'd1;
        if (r < 3)
            wall_ns = {$urandom, $urandom};
        else if (r < 10)
            wall_ns = wall_ns + {16'd0, win_len} + 64'd1 + 64'($urandom_range(0, 50));
        else
            wall_ns = wall_ns + ({$urandom, $urandom} % step);
        w = udp_word(pool_addr[pick], pool_port[pick], 16'($urandom_range(8, 1500)), wall_ns);
        if ($urandom_range(0, 4) == 0)
            w.udp_length = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
            w.frame_len = 16'($urandom_range(42, 65535));
        else
            w.frame_len = 16'($urandom_range(42, 1514));
        if (r >= 88 && r < 92)
        begin
            w.frame_len = 16'($urandom_range(0, 41));
        end
        else if (r >= 92)
        begin
            w.frame_len   = 16'($urandom);
            w.ether_type  = $urandom_range(0, 1) ? 16'($urandom) : ETHERTYPE_IPV4;
            w.ip_protocol = $urandom_range(0, 1) ? 8'($urandom) : PROTO_UDP;
            w.src_addr    = $urandom;
            w.src_port    = 16'($urandom);
        end
        queue_word(w);
    endtask

    // Build a flow pool with two slot collisions, then send n words
    task automatic run_flows(int n);
        logic [15:0] d;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i >= POOL_SIZE - 2)
            begin
                d = 16'($urandom_range(1, 65535));
                pool_addr[i] = pool_addr[i - 2] ^ {16'd0, d};
                pool_port[i] = pool_port[i - 2] ^ d;
            end
            else
            begin
                pool_addr[i] = $urandom;
                pool_port[i] = 16'($urandom);
            end
        end
        for (int i = 0; i < n; i++)
            queue_random_word();
        settle();
    endtask

    // Check verdict words, then predict for each accepted header word
    always @(posedge clk)
    begin : watch
        hdr_word_t     w;
        verdict_word_t exp_v;
        hdr_took <= hdr.valid && hdr.ready;
        if (res.valid === 1'b1 && res.ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("verdict word with no header waiting for it");
                mismatches++;
            end
            else
            begin
                exp_v = expected_verdicts.pop_front();
                if (res.verdict !== exp_v.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", exp_v.verdict, res.verdict);
                    mismatches++;
                end
                if (res.reason !== exp_v.reason)
                begin
                    $error("reason: expected %0d, got %0d", exp_v.reason, res.reason);
                    mismatches++;
                end
                outstanding--;
            end
        end
        if (hdr.valid && hdr.ready === 1'b1)
        begin
            w.frame_len   = hdr.frame_len;
            w.ether_type  = hdr.ether_type;
            w.ip_protocol = hdr.ip_protocol;
            w.src_addr    = hdr.src_addr;
            w.src_port    = hdr.src_port;
            w.udp_length  = hdr.udp_length;
            w.now_ns      = hdr.now_ns;
            expected_verdicts.push_back(police_word(w));
        end
    end

    // Advance the header word after a handshake; throttle both sides
    always @(negedge clk)
    begin : drive
        hdr_word_t w;
        if (!hdr.valid || hdr_took)
        begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                w = pending_words.pop_front();
                hdr.valid       <= 1'b1;
                hdr.frame_len   <= w.frame_len;
                hdr.ether_type  <= w.ether_type;
                hdr.ip_protocol <= w.ip_protocol;
                hdr.src_addr    <= w.src_addr;
                hdr.src_port    <= w.src_port;
                hdr.udp_length  <= w.udp_length;
                hdr.now_ns      <= w.now_ns;
            end
            else
            begin
                hdr.valid <= 1'b0;
            end
        end
        res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin : stimulus
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        hdr.valid       = 1'b0;
        hdr.frame_len   = '0;
        hdr.ether_type  = '0;
        hdr.ip_protocol = '0;
        hdr.src_addr    = '0;
        hdr.src_port    = '0;
        hdr.udp_length  = '0;
        hdr.now_ns      = '0;
        res.ready       = 1'b0;
        lim_packets     = PACKET_LIMIT_RST;
        lim_bytes       = BYTE_LIMIT_RST;
        win_len         = WINDOW_LENGTH_RST;
        wall_ns         = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            flow_valid[i] = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 88;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Header checks at each stage, field extremes, first counted flows
        queue_word(raw_word(16'd0, ETHERTYPE_IPV4, PROTO_UDP));
        queue_word(raw_word(16'd13, ETHERTYPE_IPV4, PROTO_UDP));
        queue_word(raw_word(16'd14, 16'h86DD, PROTO_UDP));
        queue_word(raw_word(16'd33, ETHERTYPE_IPV4, PROTO_UDP));
        queue_word(raw_word(16'd34, ETHERTYPE_IPV4, 8'd6));
        queue_word(raw_word(16'd41, ETHERTYPE_IPV4, PROTO_UDP));
        queue_word(raw_word(16'hFFFF, 16'hFFFF, 8'hFF));
        queue_word(raw_word(16'd1514, ETHERTYPE_IPV4, 8'hFF));
        queue_word(udp_word(32'hC0A8_0001, 16'd5000, 16'd100, 64'd1000));
        queue_word(udp_word(32'hC0A8_0001, 16'd5000, 16'hFFFF, 64'd2000));
        queue_word(udp_word(32'hFFFF_FFFF, 16'hFFFF, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        queue_word(udp_word(32'd0, 16'd0, 16'd0, 64'd0));
        settle();

        // Tight limits: byte limit, packet limit, expiry, clock going back, eviction
        write_reg(REG_PACKET_LIMIT, 48'd3);
        write_reg(REG_BYTE_LIMIT, 48'd1000);
        write_reg(REG_WINDOW_LENGTH, 48'd500);
        queue_word(udp_word(32'h0A01_0203, 16'd4000, 16'd300, 64'd10000));
        queue_word(udp_word(32'h0A01_0203, 16'd4000, 16'd300, 64'd10100));
        queue_word(udp_word(32'h0A01_0203, 16'd4000, 16'd400, 64'd10200));
        queue_word(udp_word(32'h0A01_0203, 16'd4000, 16'd399, 64'd10300));
        queue_word(udp_word(32'h0A01_0203, 16'd4000, 16'd0, 64'd10400));
        queue_word(udp_word(32'h0A01_0203, 16'd4000, 16'd10, 64'd10501));
        queue_word(udp_word(32'h0A01_0203, 16'd4000, 16'd10, 64'd5));
        queue_word(udp_word(32'h0A01_0203 ^ 32'h1234, 16'd4000 ^ 16'h1234, 16'd10, 64'd6));
        queue_word(udp_word(32'h0A01_0203, 16'd4000, 16'd10, 64'd7));
        settle();

        // Zero packet limit, then zero byte limit
        write_reg(REG_PACKET_LIMIT, 48'd0);
        queue_word(udp_word(32'h0B00_0001, 16'd7, 16'd1, 64'd100));
        settle();
        write_reg(REG_PACKET_LIMIT, 48'd10);
        write_reg(REG_BYTE_LIMIT, 48'd0);
        queue_word(udp_word(32'h0B00_0001, 16'd7, 16'd0, 64'd100));
        queue_word(raw_word(16'd60, ETHERTYPE_IPV4, 8'd1));
        settle();

        // Zero window: same time stays in window, one ns later restarts
        write_reg(REG_BYTE_LIMIT, 48'd10000);
        write_reg(REG_WINDOW_LENGTH, 48'd0);
        queue_word(udp_word(32'h0C00_0001, 16'd9, 16'd20, 64'd100));
        queue_word(udp_word(32'h0C00_0001, 16'd9, 16'd20, 64'd100));
        queue_word(udp_word(32'h0C00_0001, 16'd9, 16'd20, 64'd101));
        settle();

        // Random traffic, upper write bits dropped and unused index ignored
        write_reg(REG_PACKET_LIMIT, {16'hA5C3, 32'd5});
        write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_BYTE_LIMIT, {16'h5A3C, 32'd6000});
        write_reg(REG_WINDOW_LENGTH, 48'd20000);
        run_flows(180);

        // Swap the throttling; largest limits, then very small ones
        send_idle_pct = 88;
        recv_idle_pct = 33;
        write_reg(REG_PACKET_LIMIT, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_BYTE_LIMIT, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_WINDOW_LENGTH, 48'hFFFF_FFFF_FFFF);
        run_flows(120);
        write_reg(REG_PACKET_LIMIT, 48'd2);
        write_reg(REG_BYTE_LIMIT, 48'd3000);
        write_reg(REG_WINDOW_LENGTH, 48'd1);
        run_flows(100);

        // Full rate on both sides; reset limits, then moderate ones
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_PACKET_LIMIT, {16'd0, PACKET_LIMIT_RST});
        write_reg(REG_BYTE_LIMIT, {16'd0, BYTE_LIMIT_RST});
        write_reg(REG_WINDOW_LENGTH, WINDOW_LENGTH_RST);
        run_flows(60);
        write_reg(REG_PACKET_LIMIT, 48'd8);
        write_reg(REG_BYTE_LIMIT, 48'd40000);
        write_reg(REG_WINDOW_LENGTH, 48'd5000);
        run_flows(100);

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin : watchdog
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
